[rtl/sct_pkg.sv]
// Shared types, codes and character constants for the shell command tokenizer.
// Used by sct_step, sct_outq and shell_command_tokenizer; depends on nothing.
package sct_pkg;

  // Word length limit ceiling and register reset value
  localparam logic [9:0] WORD_LIMIT_MAX = 10'd1023;
  localparam logic [9:0] WORD_LIMIT_RST = 10'd150;

  // Output queue depth
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // Lexer modes
  localparam logic [1:0] MODE_NEUTRAL = 2'd0;
  localparam logic [1:0] MODE_GT      = 2'd1;
  localparam logic [1:0] MODE_QUOTE   = 2'd2;
  localparam logic [1:0] MODE_WORD    = 2'd3;

  // Token kinds
  localparam logic [3:0] K_CHAR  = 4'd0;
  localparam logic [3:0] K_WORD  = 4'd1;
  localparam logic [3:0] K_COMMA = 4'd2;
  localparam logic [3:0] K_SEMI  = 4'd3;
  localparam logic [3:0] K_AMP   = 4'd4;
  localparam logic [3:0] K_BAR   = 4'd5;
  localparam logic [3:0] K_LT    = 4'd6;
  localparam logic [3:0] K_EQU   = 4'd7;
  localparam logic [3:0] K_NL    = 4'd8;
  localparam logic [3:0] K_GT    = 4'd9;
  localparam logic [3:0] K_GTGT  = 4'd10;
  localparam logic [3:0] K_ERROR = 4'd11;
  localparam logic [3:0] K_END   = 4'd12;

  // Characters of interest
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQU   = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Input word
  typedef struct packed {
    logic [7:0] in_char;
    logic       at_end;
  } sct_in_t;

  // Result word
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] out_char;
    logic       last;
  } sct_out_t;

  // Lexer state
  typedef struct packed {
    logic [1:0] mode;
    logic       esc;
    logic [9:0] cnt;
  } sct_state_t;

  // One candidate token plus the state it leaves behind
  typedef struct packed {
    logic       v;
    logic [3:0] kind;
    logic [7:0] ch;
    logic [1:0] mode;
    logic [9:0] cnt;
  } sct_tok_t;

  // Everything one input word produces
  typedef struct packed {
    logic [1:0] n;
    sct_out_t   r0;
    sct_out_t   r1;
    sct_state_t nxt;
  } sct_step_t;

endpackage

[rtl/sct_step.sv]
// Next-state and token logic of the tokenizer for one input word.
// Depends on sct_pkg.
module sct_step import sct_pkg::*; (
  input  sct_in_t    in_data,
  input  sct_state_t cur,
  input  logic [9:0] limit,
  output sct_step_t  res
);

  // Count one word character; replace it with error at the limit
  function automatic sct_tok_t accept_char(input logic [7:0] c, input logic [9:0] cnt,
                                           input logic [9:0] lim, input logic [1:0] mode);
    logic [9:0] cnt1;
    sct_tok_t   t;
    cnt1 = cnt + 10'd1;
    t.v  = 1'b1;
    if (cnt1 >= lim) begin
      t.kind = K_ERROR;
      t.ch   = 8'd0;
      t.mode = MODE_NEUTRAL;
      t.cnt  = 10'd0;
    end else begin
      t.kind = K_CHAR;
      t.ch   = c;
      t.mode = mode;
      t.cnt  = cnt1;
    end
    return t;
  endfunction

  // Handle a character seen from neutral
  function automatic sct_tok_t neutral_char(input logic [7:0] c, input logic [9:0] lim);
    sct_tok_t t;
    t.v    = 1'b1;
    t.kind = K_CHAR;
    t.ch   = 8'd0;
    t.mode = MODE_NEUTRAL;
    t.cnt  = 10'd0;
    case (c)
      CH_COMMA: t.kind = K_COMMA;
      CH_SEMI:  t.kind = K_SEMI;
      CH_AMP:   t.kind = K_AMP;
      CH_BAR:   t.kind = K_BAR;
      CH_LT:    t.kind = K_LT;
      CH_EQU:   t.kind = K_EQU;
      CH_NL:    t.kind = K_NL;
      CH_SPACE: t.v    = 1'b0;
      CH_TAB:   t.v    = 1'b0;
      CH_GT: begin
        t.v    = 1'b0;
        t.mode = MODE_GT;
      end
      CH_QUOTE: begin
        t.v    = 1'b0;
        t.mode = MODE_QUOTE;
      end
      default: t = accept_char(c, 10'd0, lim, MODE_WORD);
    endcase
    return t;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_AMP) || (c == CH_BAR) ||
           (c == CH_LT) || (c == CH_GT) || (c == CH_NL) || (c == CH_SPACE) ||
           (c == CH_TAB) || (c == CH_EQU);
  endfunction

  logic [9:0] lim;
  sct_tok_t   tn;
  sct_tok_t   ta;
  sct_step_t  s;

  // Cap the configured limit
  assign lim = (limit > WORD_LIMIT_MAX) ? WORD_LIMIT_MAX : limit;
  assign tn  = neutral_char(in_data.in_char, lim);
  assign ta  = accept_char(in_data.in_char, cur.cnt, lim, cur.mode);

  // Pick results and next state by mode
  always_comb begin
    s          = '0;
    s.nxt      = cur;
    if (in_data.at_end) begin
      s.n       = 2'd1;
      s.r0.kind = K_END;
      s.nxt     = '0;
    end else begin
      case (cur.mode)
        MODE_NEUTRAL: begin
          s.n           = {1'b0, tn.v};
          s.r0.kind     = tn.kind;
          s.r0.out_char = tn.ch;
          s.nxt.mode    = tn.mode;
          s.nxt.cnt     = tn.cnt;
          s.nxt.esc     = 1'b0;
        end
        MODE_GT: begin
          s.nxt = '0;
          if (in_data.in_char == CH_GT) begin
            s.n       = 2'd1;
            s.r0.kind = K_GTGT;
          end else begin
            s.n           = tn.v ? 2'd2 : 2'd1;
            s.r0.kind     = K_GT;
            s.r1.kind     = tn.kind;
            s.r1.out_char = tn.ch;
            s.nxt.mode    = tn.mode;
            s.nxt.cnt     = tn.cnt;
          end
        end
        MODE_QUOTE: begin
          if (cur.esc || ((in_data.in_char != CH_BSL) && (in_data.in_char != CH_QUOTE))) begin
            s.n           = 2'd1;
            s.r0.kind     = ta.kind;
            s.r0.out_char = ta.ch;
            s.nxt.mode    = ta.mode;
            s.nxt.cnt     = ta.cnt;
            s.nxt.esc     = 1'b0;
          end else if (in_data.in_char == CH_BSL) begin
            s.nxt.esc = 1'b1;
          end else begin
            s.n       = 2'd1;
            s.r0.kind = K_WORD;
            s.nxt     = '0;
          end
        end
        default: begin
          if (is_delim(in_data.in_char)) begin
            s.n           = tn.v ? 2'd2 : 2'd1;
            s.r0.kind     = K_WORD;
            s.r1.kind     = tn.kind;
            s.r1.out_char = tn.ch;
            s.nxt.mode    = tn.mode;
            s.nxt.cnt     = tn.cnt;
            s.nxt.esc     = 1'b0;
          end else begin
            s.n           = 2'd1;
            s.r0.kind     = ta.kind;
            s.r0.out_char = ta.ch;
            s.nxt.mode    = ta.mode;
            s.nxt.cnt     = ta.cnt;
          end
        end
      endcase
    end
    // Flag the final result of this word
    s.r0.last = (s.n == 2'd1);
    s.r1.last = (s.n == 2'd2);
  end

  assign res = s;

endmodule

[rtl/sct_outq.sv]
// Small result queue: takes up to two result words per cycle, hands out one.
// Depends on sct_pkg.
module sct_outq import sct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [1:0] push_n,
  input  sct_out_t push0,
  input  sct_out_t push1,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output sct_out_t out_data
);

  sct_out_t               mem [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]     wptr_r, wptr_nxt;
  logic [OUTQ_AW-1:0]     rptr_r, rptr_nxt;
  logic [OUTQ_AW:0]       count_r, count_nxt;
  logic                   pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rptr_r];
  assign pop       = out_valid && out_ready;
  // Leave space for the largest burst of one word
  assign room      = (count_r <= (OUTQ_AW+1)'(OUTQ_DEPTH - 2));

  // Advance pointers and count
  always_comb begin
    wptr_nxt  = wptr_r + OUTQ_AW'(push_n);
    rptr_nxt  = rptr_r + OUTQ_AW'(pop);
    count_nxt = count_r + (OUTQ_AW+1)'(push_n) - (OUTQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wptr_r + OUTQ_AW'(1)] <= push1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OUTQ_AW+1)'(OUTQ_DEPTH))
    else $error("result queue count beyond depth");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("push into queue without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    OUTQ_AW'(wptr_r - rptr_r) == OUTQ_AW'(count_r))
    else $error("queue pointers disagree with count");

endmodule

[rtl/shell_command_tokenizer.sv]
// Top level of the shell command tokenizer: state registers, limit register,
// step logic and result queue. Depends on sct_pkg, sct_step and sct_outq.
//
// Usage:
//   in_valid/in_ready/in_data carry one command-line byte per word, or an
//   end marker (at_end). out_valid/out_ready/out_data carry tokens: word
//   characters, delimiters, word, error and end; last marks the final token
//   caused by an input word. A word may cause zero, one or two tokens.
//   cfg_we/cfg_wdata write the word length limit while the block is idle.
// Output: each token is stored in the result queue and shown at out_data.
// Throughput: one input byte per cycle while out_ready is high and each byte
//   yields at most one token; the output port drains one token per cycle, so
//   bytes that yield two tokens (closing a word on a delimiter, a lone '>'
//   before another token) fill the queue. A four-entry queue sets in_ready.
// Reset: lexer returns to neutral, queue empties, limit becomes 150.
// Stall: when out_ready is low, tokens wait in the queue and in_ready drops
//   once fewer than two entries are free; nothing is lost.
module shell_command_tokenizer import sct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sct_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sct_out_t   out_data,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  sct_state_t st_r, st_nxt;
  logic [9:0] limit_r;
  sct_step_t  step;
  logic       accept;
  logic [1:0] push_n;

  sct_step u_step (
    .in_data (in_data),
    .cur     (st_r),
    .limit   (limit_r),
    .res     (step)
  );

  assign accept = in_valid && in_ready;
  assign push_n = accept ? step.n : 2'd0;
  assign st_nxt = accept ? step.nxt : st_r;

  sct_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (step.r0),
    .push1     (step.r1),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Hold lexer state and limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      limit_r <= WORD_LIMIT_RST;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.at_end) |=> (st_r == '0))
    else $error("end marker did not clear lexer state");

  a_neutral_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r.mode == MODE_NEUTRAL) || (st_r.mode == MODE_GT)) |-> (st_r.cnt == 10'd0))
    else $error("word count held outside a word");

  a_esc_quote: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.esc |-> (st_r.mode == MODE_QUOTE))
    else $error("escape pending outside a quote");

  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.at_end) |-> (step.n == 2'd1 && step.r0.kind == K_END))
    else $error("end marker without end token");

endmodule
